[src/one_pkg.sv]
// package with shared types and constants for the octree neighbor enumerator
`default_nettype none

package one_pkg;

  // field widths
  localparam int BOX_W  = 30;
  localparam int LVL_W  = 4;
  localparam int CNT_W  = 5;
  // per-axis coordinate width carried by a 30-bit box number
  localparam int AXIS_W = BOX_W / 3;
  // width wide enough to hold 2^level - 1 for any 4-bit level
  localparam int TOP_W  = 1 << LVL_W;

  // deepest level accepted
  localparam logic [LVL_W-1:0] MAX_LEVEL = LVL_W'(10);

  // per-axis offset codes
  localparam int OFS_W = 2;
  localparam logic [OFS_W-1:0] OFS_MINUS = 2'd0;
  localparam logic [OFS_W-1:0] OFS_ZERO  = 2'd1;
  localparam logic [OFS_W-1:0] OFS_PLUS  = 2'd2;

  // one combination of per-axis offsets, x outermost, z innermost
  typedef struct packed {
    logic [OFS_W-1:0] i;
    logic [OFS_W-1:0] j;
    logic [OFS_W-1:0] k;
  } ptr_t;

endpackage

`default_nettype wire

[src/octree_neighbor_enumerator.sv]
// octree neighbor enumerator: lists every box touching a Morton-coded box
//
//  channel | signals                                | payload
//  --------+----------------------------------------+-------------------------------------
//  in      | in_valid, in_stall (driven here)       | box_number[29:0], level[3:0]
//  out     | out_valid, out_stall (driven by sink)  | neighbor_box, neighbor_count, last, error
//
// An item gives one result per cycle unless out_stall holds the output register:
// neighbor_count results (7 to 26) from the 3x3x3 offset walker, or one if out of range.
// The next item is taken in the cycle the current item's last result enters the
// output register, so items follow each other without a gap.
// Reset (rst, synchronous) empties the walker and the output register.
// out_stall holds the output register and, through it, the walker and in_stall.
`default_nettype none

module octree_neighbor_enumerator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [one_pkg::BOX_W-1:0]   box_number,
  input  wire logic [one_pkg::LVL_W-1:0]   level,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [one_pkg::BOX_W-1:0]        neighbor_box,
  output logic [one_pkg::CNT_W-1:0]        neighbor_count,
  output logic                             last,
  output logic                             error
);

  localparam int AW = one_pkg::AXIS_W;
  localparam int CW = one_pkg::CNT_W;

  // single step through the offset space within [lo, hi] per axis
  function automatic one_pkg::ptr_t adv(one_pkg::ptr_t p, one_pkg::ptr_t lo,
                                        one_pkg::ptr_t hi);
    one_pkg::ptr_t r;
    r = p;
    if (p.k != hi.k) begin
      r.k = p.k + 2'd1;
    end else begin
      r.k = lo.k;
      if (p.j != hi.j) begin
        r.j = p.j + 2'd1;
      end else begin
        r.j = lo.j;
        r.i = p.i + 2'd1;
      end
    end
    return r;
  endfunction

  // the box itself is never emitted
  function automatic one_pkg::ptr_t skip_self(one_pkg::ptr_t p, one_pkg::ptr_t lo,
                                              one_pkg::ptr_t hi);
    one_pkg::ptr_t r;
    r = p;
    if (p.i == one_pkg::OFS_ZERO && p.j == one_pkg::OFS_ZERO && p.k == one_pkg::OFS_ZERO)
      r = adv(p, lo, hi);
    return r;
  endfunction

  // apply an offset code to a coordinate
  function automatic logic [AW-1:0] shift_coord(logic [AW-1:0] t,
                                                logic [one_pkg::OFS_W-1:0] o);
    logic [AW-1:0] r;
    r = t;
    case (o)
      one_pkg::OFS_MINUS: r = t - AW'(1);
      one_pkg::OFS_ZERO:  r = t;
      one_pkg::OFS_PLUS:  r = t + AW'(1);
      default:            r = t;
    endcase
    return r;
  endfunction

  // interleave per-axis coordinates into a Morton number
  function automatic logic [one_pkg::BOX_W-1:0] weave(logic [AW-1:0] xc, logic [AW-1:0] yc,
                                                      logic [AW-1:0] zc);
    logic [one_pkg::BOX_W-1:0] r;
    r = '0;
    for (int b = 0; b < AW; b++) begin
      r[3*b+2] = xc[b];
      r[3*b+1] = yc[b];
      r[3*b]   = zc[b];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input decode
  logic [AW-1:0]            in_x, in_y, in_z;
  logic                     in_err;
  logic [one_pkg::TOP_W-1:0] in_top;
  one_pkg::ptr_t            in_lo, in_hi, in_first;
  logic [1:0]               nx, ny, nz;
  logic [CW-1:0]            in_cnt;

  // split the Morton number into axes
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      in_x[b] = box_number[3*b+2];
      in_y[b] = box_number[3*b+1];
      in_z[b] = box_number[3*b];
    end
  end

  // range checks on level and box number
  always_comb begin
    in_err = (level == '0) || (level > one_pkg::MAX_LEVEL);
    for (int d = 0; d < AW; d++) begin
      if (box_number[3*d +: 3] != 3'b000 && one_pkg::LVL_W'(d) >= level)
        in_err = 1'b1;
    end
  end

  // per-axis offset bounds, clamped at 0 and at 2^level-1
  assign in_top = (one_pkg::TOP_W'(1) << level) - one_pkg::TOP_W'(1);

  always_comb begin
    in_lo.i = (in_x != '0) ? one_pkg::OFS_MINUS : one_pkg::OFS_ZERO;
    in_lo.j = (in_y != '0) ? one_pkg::OFS_MINUS : one_pkg::OFS_ZERO;
    in_lo.k = (in_z != '0) ? one_pkg::OFS_MINUS : one_pkg::OFS_ZERO;
    in_hi.i = (one_pkg::TOP_W'(in_x) < in_top) ? one_pkg::OFS_PLUS : one_pkg::OFS_ZERO;
    in_hi.j = (one_pkg::TOP_W'(in_y) < in_top) ? one_pkg::OFS_PLUS : one_pkg::OFS_ZERO;
    in_hi.k = (one_pkg::TOP_W'(in_z) < in_top) ? one_pkg::OFS_PLUS : one_pkg::OFS_ZERO;
  end

  assign in_first = skip_self(in_lo, in_lo, in_hi);

  // neighbor count: product of per-axis candidate counts, minus the box itself
  assign nx = in_hi.i - in_lo.i + 2'd1;
  assign ny = in_hi.j - in_lo.j + 2'd1;
  assign nz = in_hi.k - in_lo.k + 2'd1;
  assign in_cnt = CW'(CW'(nx) * CW'(ny) * CW'(nz)) - CW'(1);

  // ---------------------------------------------------------------------------
  // walker registers
  logic                busy, busy_next;
  logic                err_r;
  logic [AW-1:0]       x_r, y_r, z_r;
  one_pkg::ptr_t       lo_r, hi_r, ptr, ptr_next;
  logic [CW-1:0]       cnt_r, n_r, n_next;

  logic out_free, emit, cur_last, in_take;

  assign out_free = !out_valid || !out_stall;
  assign emit     = busy && out_free;
  assign cur_last = err_r || (n_r + CW'(1) == cnt_r);
  assign in_stall = busy && !(out_free && cur_last);
  assign in_take  = in_valid && !in_stall;

  // next walker state
  always_comb begin
    busy_next = busy;
    ptr_next  = ptr;
    n_next    = n_r;
    if (emit) begin
      ptr_next = skip_self(adv(ptr, lo_r, hi_r), lo_r, hi_r);
      n_next   = n_r + CW'(1);
      if (cur_last)
        busy_next = 1'b0;
    end
    if (in_take) begin
      busy_next = 1'b1;
      ptr_next  = in_first;
      n_next    = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= busy_next;
    end
  end

  // item payload and walk position
  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    n_r <= n_next;
    if (in_take) begin
      err_r <= in_err;
      x_r   <= in_x;
      y_r   <= in_y;
      z_r   <= in_z;
      lo_r  <= in_lo;
      hi_r  <= in_hi;
      cnt_r <= in_cnt;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (err_r) begin
        neighbor_box   <= '0;
        neighbor_count <= '0;
        last           <= 1'b1;
        error          <= 1'b1;
      end else begin
        neighbor_box   <= weave(shift_coord(x_r, ptr.i), shift_coord(y_r, ptr.j),
                                shift_coord(z_r, ptr.k));
        neighbor_count <= cnt_r;
        last           <= cur_last;
        error          <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // an error transaction is always the only and final one of its item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && neighbor_count == '0)
    else $error("error result without last");

  // a good item always has between 7 and 26 neighbors
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> neighbor_count >= CW'(7) && neighbor_count <= CW'(26))
    else $error("neighbor count out of range");

  // the walker never runs past the neighbor count
  assert property (@(posedge clk) disable iff (rst)
    busy && !err_r |-> n_r < cnt_r)
    else $error("walker ran past its count");

  // a taken input item keeps the walker busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_take |=> busy)
    else $error("accepted item lost");

  // a walker that is free to move and not on its last result stays busy
  assert property (@(posedge clk) disable iff (rst)
    emit && !cur_last |=> busy && n_r == $past(n_r) + CW'(1))
    else $error("walker stopped early");
`endif

endmodule

`default_nettype wire

[tb/octree_neighbor_enumerator_checker.sv]
// result checker for the octree neighbor enumerator: predicts neighbor lists and compares
`timescale 1ns / 1ps

module octree_neighbor_enumerator_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [one_pkg::BOX_W-1:0] box_number,
  input  logic [one_pkg::LVL_W-1:0] level,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [one_pkg::BOX_W-1:0] neighbor_box,
  input  logic [one_pkg::CNT_W-1:0] neighbor_count,
  input  logic                      last,
  input  logic                      error,
  output int                        mismatches,
  output int                        boxes_seen,
  output int                        results_seen,
  output int                        faults_seen,
  output int                        outstanding
);

  // one predicted neighbor transaction
  typedef struct packed {
    logic [one_pkg::BOX_W-1:0] nbox;
    logic [one_pkg::CNT_W-1:0] cnt;
    logic                      fin;
    logic                      err;
  } neighbor_t;

  neighbor_t neighbor_q[$];
  int fail_tally   = 0;
  int box_tally    = 0;
  int result_tally = 0;
  int fault_tally  = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch at result %0d: %s", $realtime, result_tally, msg);
    fail_tally++;
  endtask

  // split the morton code, walk the clamped 3x3x3 neighborhood, re-interleave
  function automatic void enumerate_neighbors(input logic [one_pkg::BOX_W-1:0] box,
                                              input logic [one_pkg::LVL_W-1:0] lvl);
    int        coord[3];
    int        pos[3];
    int        top;
    int        total;
    int        emitted;
    logic [63:0] wide;
    logic [one_pkg::BOX_W-1:0] code;
    neighbor_t nb;
    wide = 64'(box);
    // bad level or box number of 8^level or more: single flagged transaction
    if (lvl < 1 || lvl > one_pkg::MAX_LEVEL || (wide >> (3 * int'(lvl))) != 0) begin
      nb.nbox = '0;
      nb.cnt  = '0;
      nb.fin  = 1'b1;
      nb.err  = 1'b1;
      neighbor_q.push_back(nb);
      fault_tally++;
      return;
    end
    top = (1 << lvl) - 1;
    // de-interleave: x is the top bit of each octal digit, z the bottom
    for (int a = 0; a < 3; a++) begin
      coord[a] = 0;
      for (int b = 0; b < lvl; b++)
        coord[a] |= int'(box[3*b + 2 - a]) << b;
    end
    total = 1;
    for (int a = 0; a < 3; a++)
      total *= 1 + ((coord[a] > 0) ? 1 : 0) + ((coord[a] < top) ? 1 : 0);
    total -= 1;
    emitted = 0;
    // x outermost, z innermost, skipping the box itself
    for (int dx = -1; dx <= 1; dx++)
      for (int dy = -1; dy <= 1; dy++)
        for (int dz = -1; dz <= 1; dz++) begin
          pos[0] = coord[0] + dx;
          pos[1] = coord[1] + dy;
          pos[2] = coord[2] + dz;
          if (pos[0] < 0 || pos[1] < 0 || pos[2] < 0) continue;
          if (pos[0] > top || pos[1] > top || pos[2] > top) continue;
          if (dx == 0 && dy == 0 && dz == 0) continue;
          code = '0;
          for (int b = 0; b < lvl; b++) begin
            code[3*b + 2] = pos[0][b];
            code[3*b + 1] = pos[1][b];
            code[3*b]     = pos[2][b];
          end
          emitted++;
          nb.nbox = code;
          nb.cnt  = one_pkg::CNT_W'(total);
          nb.fin  = (emitted == total);
          nb.err  = 1'b0;
          neighbor_q.push_back(nb);
        end
  endfunction

  // compare each result transaction first, then predict for a newly taken box
  always @(posedge clk) begin : watch
    neighbor_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        result_tally++;
        if (neighbor_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result box %0d count %0d last %b error %b",
                                    neighbor_box, neighbor_count, last, error));
        end else begin
          want = neighbor_q.pop_front();
          if (neighbor_box !== want.nbox)
            report_mismatch($sformatf("neighbor_box expected %0d got %0d",
                                      want.nbox, neighbor_box));
          if (neighbor_count !== want.cnt)
            report_mismatch($sformatf("neighbor_count expected %0d got %0d",
                                      want.cnt, neighbor_count));
          if (last !== want.fin)
            report_mismatch($sformatf("last expected %b got %b", want.fin, last));
          if (error !== want.err)
            report_mismatch($sformatf("error expected %b got %b", want.err, error));
        end
      end
      if (in_valid && !in_stall) begin
        box_tally++;
        enumerate_neighbors(box_number, level);
      end
      outstanding  <= neighbor_q.size();
      mismatches   <= fail_tally;
      boxes_seen   <= box_tally;
      results_seen <= result_tally;
      faults_seen  <= fault_tally;
    end
  end

endmodule

[tb/octree_neighbor_enumerator_tb.sv]
// testbench top for the octree neighbor enumerator: stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps

module octree_neighbor_enumerator_tb;

  localparam int ITEMS          = 480;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 40;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [one_pkg::BOX_W-1:0] box_number;
  logic [one_pkg::LVL_W-1:0] level;
  logic                      out_valid;
  logic                      out_stall;
  logic [one_pkg::BOX_W-1:0] neighbor_box;
  logic [one_pkg::CNT_W-1:0] neighbor_count;
  logic                      last;
  logic                      error;

  int mismatches;
  int boxes_seen;
  int results_seen;
  int faults_seen;
  int outstanding;
  int quiet_cycles = 0;
  bit idle_on = 1'b0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  octree_neighbor_enumerator uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .box_number     (box_number),
    .level          (level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .neighbor_box   (neighbor_box),
    .neighbor_count (neighbor_count),
    .last           (last),
    .error          (error)
  );

  octree_neighbor_enumerator_checker neighbor_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .box_number     (box_number),
    .level          (level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .neighbor_box   (neighbor_box),
    .neighbor_count (neighbor_count),
    .last           (last),
    .error          (error),
    .mismatches     (mismatches),
    .boxes_seen     (boxes_seen),
    .results_seen   (results_seen),
    .faults_seen    (faults_seen),
    .outstanding    (outstanding)
  );

  // interleave per-axis coordinates into a morton box number
  function automatic logic [one_pkg::BOX_W-1:0] compose_box(input int unsigned x,
                                                            input int unsigned y,
                                                            input int unsigned z,
                                                            input int lvl);
    logic [one_pkg::BOX_W-1:0] code;
    code = '0;
    for (int b = 0; b < lvl; b++) begin
      code[3*b + 2] = x[b];
      code[3*b + 1] = y[b];
      code[3*b]     = z[b];
    end
    return code;
  endfunction

  // coordinate biased toward the faces of the cube
  function automatic int unsigned pick_coord(input int lvl);
    int unsigned top;
    top = (1 << lvl) - 1;
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return top;
      2:       return (top > 0) ? 1 : 0;
      3:       return (top > 0) ? top - 1 : 0;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // one input transaction, with an optional idle burst in front
  task automatic send_item(input logic [one_pkg::BOX_W-1:0] box,
                           input logic [one_pkg::LVL_W-1:0] lvl);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    box_number <= box;
    level      <= lvl;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // result side stall bursts
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("octree_neighbor_enumerator_tb: FAIL");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    logic [one_pkg::BOX_W-1:0] box;
    int                        lvl;
    int                        pick;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    box_number <= '0;
    level      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every box of level 1 (all corners)
    for (int i = 0; i < 8; i++)
      send_item(one_pkg::BOX_W'(i), one_pkg::LVL_W'(1));
    // deepest level: corners, a fully interior box and an edge box; then level-2 boxes
    send_item('0, one_pkg::MAX_LEVEL);
    send_item('1, one_pkg::MAX_LEVEL);
    send_item(compose_box(512, 512, 512, 10), one_pkg::MAX_LEVEL);
    send_item(compose_box(1023, 511, 0, 10), one_pkg::MAX_LEVEL);
    send_item(compose_box(1, 1, 1, 2), one_pkg::LVL_W'(2));
    send_item(one_pkg::BOX_W'(63), one_pkg::LVL_W'(2));
    // bad levels
    send_item('0, one_pkg::LVL_W'(0));
    send_item('1, one_pkg::LVL_W'(0));
    send_item('0, one_pkg::MAX_LEVEL + one_pkg::LVL_W'(1));
    send_item(one_pkg::BOX_W'(5), '1);
    // box numbers just past the level's range
    send_item(one_pkg::BOX_W'(64), one_pkg::LVL_W'(2));
    send_item(one_pkg::BOX_W'(512), one_pkg::LVL_W'(3));
    send_item(one_pkg::BOX_W'(1) << 27, one_pkg::LVL_W'(9));

    // random: mostly well-formed boxes near faces, some faults
    for (int n = 0; n < ITEMS; n++) begin
      idle_on = !(n >= ITEMS - 60 || (n >= 200 && n < 260));
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        lvl = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(11, 15);
        box = one_pkg::BOX_W'($urandom);
      end else if (pick == 1) begin
        lvl = $urandom_range(1, 9);
        box = one_pkg::BOX_W'($urandom);
        box[3*lvl + $urandom_range(0, 29 - 3*lvl)] = 1'b1;
      end else if (pick == 2) begin
        lvl = 10;
        box = one_pkg::BOX_W'($urandom);
      end else begin
        lvl = $urandom_range(1, 10);
        box = compose_box(pick_coord(lvl), pick_coord(lvl), pick_coord(lvl), lvl);
      end
      send_item(box, one_pkg::LVL_W'(lvl));
    end
    in_valid <= 1'b0;

    // drain, then allow for anything trailing
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d boxes (%0d out of range or bad level), %0d neighbor transactions",
             boxes_seen, faults_seen, results_seen);
    if (mismatches == 0)
      $display("octree_neighbor_enumerator_tb: PASS");
    else
      $display("octree_neighbor_enumerator_tb: FAIL");
    $finish;
  end

endmodule

[files.f]
src/one_pkg.sv
src/octree_neighbor_enumerator.sv
tb/octree_neighbor_enumerator_checker.sv
tb/octree_neighbor_enumerator_tb.sv
